@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the merge unit. Each macro
// expects clk and arst_n to be visible where it is used.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KW_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/kwsm_pkg.sv @@
// ----------------------------------------------------------------------------
// K-way merge package
// Transfer types, sizing constants and the control bundle shared by the
// sequencer and the running-minimum unit.
// ----------------------------------------------------------------------------
package kwsm_pkg;

	localparam int VALUE_W   = 32;
	localparam int INDEX_W   = 3;
	localparam int LISTS_DEF = 8;
	localparam int DEPTH_DEF = 8;
	// Largest number of results one set can produce.
	localparam int MAX_OUT   = 64;
	localparam int REM_W     = $clog2(MAX_OUT + 1);

	// One input transfer.
	typedef struct packed {
		logic                      has_item;
		logic [INDEX_W-1:0]        list_index;
		logic signed [VALUE_W-1:0] value;
		logic                      close_set;
	} in_item_t;

	// One result transfer.
	typedef struct packed {
		logic signed [VALUE_W-1:0] merged_value;
		logic                      is_last;
		logic                      overflowed;
	} out_item_t;

	// Control from the sequencer to the running-minimum unit.
	typedef struct packed {
		logic clear;
		logic pend;
	} best_ctl_t;

endpackage

@@ design/kwsm_mem.sv @@
// ----------------------------------------------------------------------------
// Sequence store
// Single-write, single-read memory holding every buffered value, with a
// registered read port.
// ----------------------------------------------------------------------------
module kwsm_mem #(
	parameter int ENTRIES = kwsm_pkg::LISTS_DEF * kwsm_pkg::DEPTH_DEF,
	parameter int AW      = $clog2(ENTRIES)
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [AW-1:0]                waddr,
	input  logic [kwsm_pkg::VALUE_W-1:0] wdata,
	input  logic                         re,
	input  logic [AW-1:0]                raddr,
	output logic [kwsm_pkg::VALUE_W-1:0] rdata
);
	import kwsm_pkg::*;

	logic [VALUE_W-1:0] mem_q [ENTRIES];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ design/kwsm_best.sv @@
// ----------------------------------------------------------------------------
// Running minimum
// The shared signed comparator. It folds one buffer head per cycle, while
// pend is set, into the smallest value seen so far in the current scan.
// ----------------------------------------------------------------------------
module kwsm_best #(
	parameter int LW = 3
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  kwsm_pkg::best_ctl_t                 ctl,
	input  logic [LW-1:0]                       cand_idx,
	input  logic [kwsm_pkg::VALUE_W-1:0]        cand_val,
	output logic signed [kwsm_pkg::VALUE_W-1:0] best_val,
	output logic [LW-1:0]                       best_idx
);
	import kwsm_pkg::*;

	logic                      found_q;
	logic signed [VALUE_W-1:0] val_q;
	logic [LW-1:0]             idx_q;
	logic                      take;

	// A strictly smaller head replaces the current best, so on ties the
	// lower-numbered sequence, scanned first, is kept.
	assign take     = ctl.pend && (!found_q || ($signed(cand_val) < val_q));
	assign best_val = take ? $signed(cand_val) : val_q;
	assign best_idx = take ? cand_idx : idx_q;

	// The found flag restarts at the end of every scan.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.clear) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	// Best value and its sequence number.
	always_ff @(posedge clk) begin
		if (take) begin
			val_q <= $signed(cand_val);
			idx_q <= cand_idx;
		end
	end

endmodule

@@ design/k_way_sorted_merge_unit.sv @@
// ----------------------------------------------------------------------------
// K-way sorted merge unit
// While idle the unit stores one input transfer per cycle (busy stays low),
// each value going into its sequence's buffer of DEPTH entries. The transfer
// with close_set starts the merge and raises busy, unless no value was
// stored, in which case the unit stays idle. For each result, one comparator
// and one memory read port visit the head of every sequence in turn, and a
// final drain state hands the smallest head out. At most MAX_OUT results are
// given per set. Results appear on result for exactly one cycle with strobe
// high and cannot be held off, so the receiver must take every strobe. Busy
// drops on the cycle that shows the result with is_last. The store needs no
// clearing pass after reset.
// ----------------------------------------------------------------------------
module k_way_sorted_merge_unit #(
	parameter int LISTS = kwsm_pkg::LISTS_DEF,
	parameter int DEPTH = kwsm_pkg::DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  kwsm_pkg::in_item_t  item,
	output logic                busy,
	output logic                strobe,
	output kwsm_pkg::out_item_t result
);
	import kwsm_pkg::*;

	localparam int ENTRIES = LISTS * DEPTH;
	localparam int LW      = $clog2(LISTS);
	localparam int CW      = $clog2(DEPTH + 1);
	localparam int AW      = $clog2(ENTRIES);
	localparam int TW      = $clog2(ENTRIES + 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ISSUE = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [1:0]                state_q;
	logic [CW-1:0]             fill_q [LISTS];
	logic [CW-1:0]             pos_q  [LISTS];
	logic [LISTS-1:0]          nonempty;
	logic                      ovf_q;
	logic [TW-1:0]             total_q;
	logic [REM_W-1:0]          remain_q;
	logic [LW-1:0]             scan_q;
	logic                      pend_s1;
	logic [LW-1:0]             pidx_s1;
	logic                      strobe_q;
	out_item_t                 result_q;

	logic                      accept;
	logic                      idx_ok;
	logic                      has_room;
	logic                      do_store;
	logic [LW-1:0]             in_lane;
	logic [CW-1:0]             in_fill;
	logic [TW-1:0]             total_nxt;
	logic                      mem_re;
	logic [AW-1:0]             waddr;
	logic [AW-1:0]             raddr;
	logic [VALUE_W-1:0]        rdata;
	best_ctl_t                 bctl;
	logic signed [VALUE_W-1:0] best_val;
	logic [LW-1:0]             best_idx;

	// Input transfer decode.
	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign idx_ok    = (int'(item.list_index) < LISTS);
	assign in_lane   = LW'(item.list_index);
	assign in_fill   = fill_q[in_lane];
	assign has_room  = (in_fill < CW'(DEPTH));
	assign do_store  = accept && item.has_item && idx_ok && has_room;
	assign total_nxt = total_q + TW'(do_store);
	assign waddr     = AW'(int'(in_lane) * DEPTH + int'(in_fill));

	// Per-sequence flags: a buffer still has unread values.
	always_comb begin
		for (int i = 0; i < LISTS; i++) begin
			nonempty[i] = (pos_q[i] < fill_q[i]);
		end
	end

	// Head read for the sequence under scan.
	assign mem_re = (state_q == ST_ISSUE) && nonempty[scan_q];
	assign raddr  = AW'(int'(scan_q) * DEPTH + int'(pos_q[scan_q]));

	kwsm_mem #(
		.ENTRIES(ENTRIES),
		.AW     (AW)
	) u_mem (
		.clk  (clk),
		.we   (do_store),
		.waddr(waddr),
		.wdata(item.value),
		.re   (mem_re),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign bctl.clear = (state_q == ST_DRAIN);
	assign bctl.pend  = pend_s1;

	kwsm_best #(
		.LW(LW)
	) u_best (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (bctl),
		.cand_idx(pidx_s1),
		.cand_val(rdata),
		.best_val(best_val),
		.best_idx(best_idx)
	);

	// Sequencer: load, scan every head, hand out the minimum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			for (int i = 0; i < LISTS; i++) begin
				fill_q[i] <= '0;
				pos_q[i]  <= '0;
			end
			ovf_q    <= 1'b0;
			total_q  <= '0;
			remain_q <= '0;
			scan_q   <= '0;
			pend_s1  <= 1'b0;
			pidx_s1  <= '0;
			strobe_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					pend_s1  <= 1'b0;
					strobe_q <= 1'b0;
					if (do_store) begin
						fill_q[in_lane] <= in_fill + CW'(1);
						total_q         <= total_nxt;
					end
					if (accept && item.has_item && idx_ok && !has_room) begin
						ovf_q <= 1'b1;
					end
					if (accept && item.close_set) begin
						if (total_nxt == '0) begin
							// Nothing stored: the set ends without results.
							ovf_q <= 1'b0;
						end else begin
							if (int'(total_nxt) < MAX_OUT) begin
								remain_q <= REM_W'(total_nxt);
							end else begin
								remain_q <= REM_W'(MAX_OUT);
							end
							scan_q  <= '0;
							state_q <= ST_ISSUE;
						end
					end
				end
				ST_ISSUE: begin
					strobe_q <= 1'b0;
					pend_s1  <= nonempty[scan_q];
					pidx_s1  <= scan_q;
					if (scan_q == LW'(LISTS - 1)) begin
						state_q <= ST_DRAIN;
					end else begin
						scan_q <= scan_q + LW'(1);
					end
				end
				ST_DRAIN: begin
					pend_s1  <= 1'b0;
					strobe_q <= 1'b1;
					remain_q <= remain_q - REM_W'(1);
					if (remain_q == REM_W'(1)) begin
						// Last result: empty every buffer for the next set.
						for (int i = 0; i < LISTS; i++) begin
							fill_q[i] <= '0;
							pos_q[i]  <= '0;
						end
						ovf_q   <= 1'b0;
						total_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						pos_q[best_idx] <= pos_q[best_idx] + CW'(1);
						scan_q          <= '0;
						state_q         <= ST_ISSUE;
					end
				end
				default: begin
					pend_s1  <= 1'b0;
					strobe_q <= 1'b0;
					state_q  <= ST_IDLE;
				end
			endcase
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (state_q == ST_DRAIN) begin
			result_q.merged_value <= best_val;
			result_q.is_last      <= (remain_q == REM_W'(1));
			result_q.overflowed   <= ovf_q;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule

@@ design/kwsm_checker.sv @@
// ----------------------------------------------------------------------------
// Merge unit port checker
// Watches the top-level ports and checks how results line up with busy.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kwsm_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                busy,
	input logic                strobe,
	input kwsm_pkg::out_item_t result
);
	import kwsm_pkg::*;

	// A result that is not the last one leaves the merge running.
	`KW_ASSERT_NOW(a_mid_busy, strobe && !result.is_last, busy, "merge stopped before the last result")

	// The last result shows on the cycle the unit is ready again.
	`KW_ASSERT_NOW(a_last_idle, strobe && result.is_last, !busy, "still busy on the last result")

	// Each result needs a full scan, so strobes never come back to back.
	`KW_ASSERT_NEXT(a_gap, strobe, !strobe, "two result transfers in adjacent cycles")

	// The merge only ends by giving its last result.
	`KW_ASSERT_NOW(a_end, $fell(busy), strobe && result.is_last, "busy fell without a last result")

endmodule

bind k_way_sorted_merge_unit kwsm_checker u_kwsm_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.busy  (busy),
	.strobe(strobe),
	.result(result)
);
